/* rtl/dvenc_pkg.sv */
package dvenc_pkg;

    localparam int VALUE_W = 64;
    localparam int LEAD_W = 6;
    localparam int SIZE_W = 7;
    localparam int LEN_W = 7;
    localparam int IN_TDATA_W = 64;
    localparam int OUT_TDATA_W = 88;
    localparam int FIFO_DEPTH = 4;

    localparam logic [SIZE_W-1:0] FULL_SIZE = 7'd64;
    localparam logic [LEN_W-1:0] RAW_LEN = 7'd64;
    localparam logic [LEN_W-1:0] SAME_LEN = 7'd1;
    localparam logic [LEN_W-1:0] REUSE_HDR_LEN = 7'd2;
    localparam logic [LEN_W-1:0] NEW_HDR_LEN = 7'd15;

    typedef enum logic [1:0] {
        KIND_SAME  = 2'd0,
        KIND_REUSE = 2'd1,
        KIND_NEW   = 2'd2,
        KIND_RAW   = 2'd3
    } t_code_kind;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic               start;
        logic               zero;
        logic [VALUE_W-1:0] data;   // raw value at a series start, else the XOR
        logic [LEAD_W-1:0]  lead;
        logic [LEAD_W-1:0]  trail;
    } t_front_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_flags;

    // Leading zeros by binary search; a zero word gives 63.
    function automatic logic [LEAD_W-1:0] clz64(input logic [VALUE_W-1:0] x);
        logic [VALUE_W-1:0] w;
        logic [LEAD_W-1:0]  n;
        w = x;
        n = '0;
        if (w[63:32] == 32'd0) begin n[5] = 1'b1; w = w << 32; end
        if (w[63:48] == 16'd0) begin n[4] = 1'b1; w = w << 16; end
        if (w[63:56] == 8'd0)  begin n[3] = 1'b1; w = w << 8;  end
        if (w[63:60] == 4'd0)  begin n[2] = 1'b1; w = w << 4;  end
        if (w[63:62] == 2'd0)  begin n[1] = 1'b1; w = w << 2;  end
        if (w[63] == 1'b0)     begin n[0] = 1'b1;              end
        return n;
    endfunction

    function automatic logic [LEAD_W-1:0] ctz64(input logic [VALUE_W-1:0] x);
        logic [VALUE_W-1:0] r;
        for (int i = 0; i < VALUE_W; i++) begin
            r[i] = x[VALUE_W-1-i];
        end
        return clz64(r);
    endfunction

endpackage

/* rtl/dvenc_front.sv */
module dvenc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [dvenc_pkg::VALUE_W-1:0] i_value,
    input  logic                          i_start,
    output dvenc_pkg::t_front_item        o_item
);

    logic [dvenc_pkg::VALUE_W-1:0] r_prev;
    logic [dvenc_pkg::VALUE_W-1:0] n_prev;
    logic [dvenc_pkg::VALUE_W-1:0] w_xor;

    assign w_xor = r_prev ^ i_value;

    always_comb begin
        n_prev = r_prev;
        if (i_accept) begin
            n_prev = i_value;
        end
        o_item.start = i_start;
        o_item.zero  = (w_xor == '0);
        o_item.data  = i_start ? i_value : w_xor;
        o_item.lead  = dvenc_pkg::clz64(w_xor);
        o_item.trail = dvenc_pkg::ctz64(w_xor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else begin
            r_prev <= n_prev;
        end
    end

endmodule

/* rtl/dvenc_fifo.sv */
module dvenc_fifo #(
    parameter int DEPTH = dvenc_pkg::FIFO_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  dvenc_pkg::t_front_item i_item,
    input  logic                   i_pop,
    output dvenc_pkg::t_front_item o_item,
    output dvenc_pkg::t_fifo_flags o_flags,
    output logic [CNT_W-1:0]       o_level
);

    dvenc_pkg::t_front_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign w_push = i_push && (r_count != CNT_W'(DEPTH));
    assign w_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rd_ptr];
    assign o_flags.full  = (r_count == CNT_W'(DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign o_level       = r_count;

endmodule

/* rtl/dvenc_back.sv */
module dvenc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_item_valid,
    input  dvenc_pkg::t_front_item         i_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output dvenc_pkg::t_code_kind          o_kind,
    output logic [dvenc_pkg::LEAD_W-1:0]   o_lead,
    output logic [dvenc_pkg::SIZE_W-1:0]   o_size,
    output logic [dvenc_pkg::VALUE_W-1:0]  o_payload,
    output logic [dvenc_pkg::LEN_W-1:0]    o_len
);

    logic [dvenc_pkg::LEAD_W-1:0]  r_win_lead, n_win_lead;
    logic [dvenc_pkg::SIZE_W-1:0]  r_win_size, n_win_size;
    logic [dvenc_pkg::LEAD_W-1:0]  r_win_trail, n_win_trail;
    logic                          r_valid, n_valid;
    dvenc_pkg::t_code_kind         r_kind, n_kind;
    logic [dvenc_pkg::LEAD_W-1:0]  r_lead, n_lead;
    logic [dvenc_pkg::SIZE_W-1:0]  r_size, n_size;
    logic [dvenc_pkg::VALUE_W-1:0] r_payload, n_payload;
    logic [dvenc_pkg::LEN_W-1:0]   r_len, n_len;
    logic [dvenc_pkg::SIZE_W-1:0]  w_new_size;
    logic                          w_fits;

    // The output register is free when empty or being taken this cycle.
    assign o_pop = i_item_valid && (!r_valid || i_ready);

    assign w_new_size = dvenc_pkg::FULL_SIZE
                      - {1'b0, i_item.lead} - {1'b0, i_item.trail};
    assign w_fits = (r_win_size != '0) && (r_win_lead <= i_item.lead)
                 && (r_win_trail <= i_item.trail);

    always_comb begin
        n_win_lead  = r_win_lead;
        n_win_size  = r_win_size;
        n_win_trail = r_win_trail;
        n_valid     = r_valid && !i_ready;
        n_kind      = r_kind;
        n_lead      = r_lead;
        n_size      = r_size;
        n_payload   = r_payload;
        n_len       = r_len;
        if (o_pop) begin
            n_valid   = 1'b1;
            n_lead    = '0;
            n_size    = '0;
            n_payload = '0;
            if (i_item.start) begin
                n_kind      = dvenc_pkg::KIND_RAW;
                n_size      = dvenc_pkg::FULL_SIZE;
                n_payload   = i_item.data;
                n_len       = dvenc_pkg::RAW_LEN;
                n_win_lead  = '0;
                n_win_size  = '0;
                n_win_trail = '0;
            end else if (i_item.zero) begin
                n_kind = dvenc_pkg::KIND_SAME;
                n_len  = dvenc_pkg::SAME_LEN;
            end else if (w_fits) begin
                n_kind    = dvenc_pkg::KIND_REUSE;
                n_size    = r_win_size;
                n_payload = i_item.data >> r_win_trail;
                n_len     = dvenc_pkg::REUSE_HDR_LEN + r_win_size;
            end else begin
                n_kind      = dvenc_pkg::KIND_NEW;
                n_lead      = i_item.lead;
                n_size      = w_new_size;
                n_payload   = i_item.data >> i_item.trail;
                n_len       = dvenc_pkg::NEW_HDR_LEN + w_new_size;
                n_win_lead  = i_item.lead;
                n_win_size  = w_new_size;
                n_win_trail = i_item.trail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_lead  <= '0;
            r_win_size  <= '0;
            r_win_trail <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_win_lead  <= n_win_lead;
            r_win_size  <= n_win_size;
            r_win_trail <= n_win_trail;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_lead    <= n_lead;
        r_size    <= n_size;
        r_payload <= n_payload;
        r_len     <= n_len;
    end

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_lead    = r_lead;
    assign o_size    = r_size;
    assign o_payload = r_payload;
    assign o_len     = r_len;

endmodule

/* rtl/xor_delta_value_encoder.sv */
// Channel   Dir  tdata (low bit up)                                  tuser
// s_axis    in   value[63:0]                                         start_series
// m_axis    out  leading_zeros, meaningful_bits, payload,            code_kind[1:0]
//                code_length, 4 zero bits
//
// One item per cycle sustained while the output is ready. The front takes the
// XOR and both zero counts in the cycle of the transaction and pushes the item
// into the queue; the back pops it from there and registers its codeword in
// the output register. The queue holds FIFO_DEPTH items behind the output
// register, so input keeps flowing while the output stalls until the queue
// fills. Reset clears the previous value, the window, the queue and the output
// valid; no clearing pass is needed.
module xor_delta_value_encoder #(
    parameter int FIFO_DEPTH = dvenc_pkg::FIFO_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [dvenc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // value
    input  logic                              i_s_axis_tuser,  // start_series
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // leading_zeros [5:0], meaningful_bits [12:6], payload [76:13],
    // code_length [83:77], zero fill [87:84]
    output logic [dvenc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]                        o_m_axis_tuser   // code_kind
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    dvenc_pkg::t_front_item          w_front_item;
    dvenc_pkg::t_front_item          w_queue_item;
    dvenc_pkg::t_fifo_flags          w_flags;
    logic [CNT_W-1:0]                w_level;
    logic                            w_accept;
    logic                            w_pop;
    dvenc_pkg::t_code_kind           w_kind;
    logic [dvenc_pkg::LEAD_W-1:0]    w_lead;
    logic [dvenc_pkg::SIZE_W-1:0]    w_size;
    logic [dvenc_pkg::VALUE_W-1:0]   w_payload;
    logic [dvenc_pkg::LEN_W-1:0]     w_len;

    assign o_s_axis_tready = !w_flags.full;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    dvenc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_value  (i_s_axis_tdata),
        .i_start  (i_s_axis_tuser),
        .o_item   (w_front_item)
    );

    dvenc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_flags (w_flags),
        .o_level (w_level)
    );

    dvenc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!w_flags.empty),
        .i_item       (w_queue_item),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_kind       (w_kind),
        .o_lead       (w_lead),
        .o_size       (w_size),
        .o_payload    (w_payload),
        .o_len        (w_len)
    );

    assign o_m_axis_tdata = {4'd0, w_len, w_payload, w_size, w_lead};
    assign o_m_axis_tuser = w_kind;

`ifndef SYNTHESIS
    // The queue level tracks transactions in and pops out.
    a_level_up : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_pop |=> w_level == $past(w_level) + 1'b1)
        else $error("queue level did not rise on a lone push");

    a_level_down : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && !w_accept |=> w_level == $past(w_level) - 1'b1)
        else $error("queue level did not fall on a lone pop");

    // A raw codeword always carries the whole value and no header.
    a_raw_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_kind == dvenc_pkg::KIND_RAW |->
        w_size == dvenc_pkg::FULL_SIZE && w_len == dvenc_pkg::RAW_LEN
        && w_lead == '0)
        else $error("raw codeword has wrong shape");

    a_same_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_kind == dvenc_pkg::KIND_SAME |->
        w_len == dvenc_pkg::SAME_LEN && w_size == '0 && w_payload == '0)
        else $error("same-value codeword has wrong shape");
`endif

endmodule
